// ===== rtl/core/dq_pkg.sv =====
// shared constants for the double ended queue: command and status codes,
// capacity limit and default depth; no dependencies
`default_nettype none

package dq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int LIMIT         = 50;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_PUSH_FRONT = 3'd0;
   localparam op_type OP_PUSH_BACK  = 3'd1;
   localparam op_type OP_POP_FRONT  = 3'd2;
   localparam op_type OP_POP_BACK   = 3'd3;
   localparam op_type OP_DUMP_FWD   = 3'd4;
   localparam op_type OP_DUMP_BWD   = 3'd5;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/dq_ram.sv =====
// element store of the double ended queue: one write port, one read port
// with registered read data; uses dq_pkg for the data width
`default_nettype none

module dq_ram #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire logic [dq_pkg::DATA_W-1:0]   wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic      [dq_pkg::DATA_W-1:0]   rd_data
);
   import dq_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// double ended queue top level: command decode, ring indices, occupancy
// and dump sequencer around the dq_ram element store; uses dq_pkg
//
// usage:
//   a request (req_op, req_value) is taken at a rising edge with start high
//   and busy low. every request except the unused op codes gives results on
//   rsp_status, rsp_data and rsp_last, each marked by rsp_valid for exactly
//   one cycle; rsp_last flags the final result of a request.
//   for a push or pop the result appears in the cycle after the request is
//   taken and busy stays low, so a request may follow in every cycle. a pop
//   reads the store at the edge that takes it, and the registered read data
//   is the result.
//   a dump of n elements gives its n results back to back, one store read
//   per cycle through the single read port; busy stays high after the
//   request is taken until the store read for the final result.
//   the deque holds at most min(50, DEPTH) elements. a push when full
//   reports full, a pop or dump when empty reports empty.
//   reset empties the deque and drops any dump in progress; store contents
//   are not cleared. the receiver cannot stall results.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic        [dq_pkg::OP_W-1:0]     req_op,
   input  wire logic signed [dq_pkg::DATA_W-1:0]   req_value,
   output logic                                    rsp_valid,
   output logic             [dq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [dq_pkg::DATA_W-1:0]   rsp_data,
   output logic                                    rsp_last
);
   import dq_pkg::*;

   localparam int CAP = (LIMIT < DEPTH) ? LIMIT : DEPTH;
   localparam int IW  = $clog2(DEPTH);
   localparam int OW  = $clog2(CAP + 1);

   typedef enum logic {S_IDLE, S_DUMP} state_type;

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
      return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
   endfunction

   function automatic logic [IW-1:0] prev_idx(input logic [IW-1:0] i);
      return (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
   endfunction

   state_type   state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [IW-1:0] back_ff, back_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [IW-1:0] walk_ff, walk_in;
   logic [OW-1:0] remain_ff, remain_in;
   logic          fwd_ff, fwd_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_sel_ff, rsp_sel_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic          full;
   logic          empty;

   assign full  = (occ_ff >= OW'(CAP));
   assign empty = (occ_ff == '0);
   assign busy  = (state_ff == S_DUMP);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      occ_in        = occ_ff;
      walk_in       = walk_ff;
      remain_in     = remain_ff;
      fwd_in        = fwd_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;
      rsp_sel_in    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = walk_ff;

      if (state_ff == S_DUMP) begin
         rd_en        = 1'b1;
         rd_addr      = walk_ff;
         rsp_valid_in = 1'b1;
         rsp_sel_in   = 1'b1;
         rsp_last_in  = (remain_ff == OW'(1));
         remain_in    = remain_ff - OW'(1);
         walk_in      = fwd_ff ? next_idx(walk_ff) : prev_idx(walk_ff);
         if (rsp_last_in) begin
            state_in = S_IDLE;
         end
      end else if (start) begin
         case (req_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  wr_en  = 1'b1;
                  occ_in = occ_ff + OW'(1);
                  if (empty) begin
                     wr_addr = front_ff;
                     back_in = front_ff;
                  end else if (req_op == OP_PUSH_FRONT) begin
                     front_in = prev_idx(front_ff);
                     wr_addr  = prev_idx(front_ff);
                  end else begin
                     back_in = next_idx(back_ff);
                     wr_addr = next_idx(back_ff);
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  rsp_sel_in = 1'b1;
                  occ_in     = occ_ff - OW'(1);
                  if (req_op == OP_POP_FRONT) begin
                     rd_addr = front_ff;
                     if (occ_ff > OW'(1)) begin
                        front_in = next_idx(front_ff);
                     end
                  end else begin
                     rd_addr = back_ff;
                     if (occ_ff > OW'(1)) begin
                        back_in = prev_idx(back_ff);
                     end
                  end
               end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rd_en       = 1'b1;
                  rsp_sel_in  = 1'b1;
                  fwd_in      = (req_op == OP_DUMP_FWD);
                  rd_addr     = fwd_in ? front_ff : back_ff;
                  walk_in     = fwd_in ? next_idx(front_ff) : prev_idx(back_ff);
                  remain_in   = occ_ff - OW'(1);
                  rsp_last_in = (occ_ff == OW'(1));
                  if (!rsp_last_in) begin
                     state_in = S_DUMP;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      remain_ff     <= remain_in;
      fwd_ff        <= fwd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_sel_ff    <= rsp_sel_in;
   end

   dq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_data   = rsp_sel_ff ? signed'(rd_data) : '0;

endmodule

`default_nettype wire
